### hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int BASE_W          = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 8;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;

  // Map a remainder magnitude (0..35) to '0'-'9' or 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + d_ext;
    end else begin
      return CHAR_A + d_ext - 8'd10;
    end
  endfunction

endpackage

### hw/rtl/itoa_ram.sv
`timescale 1ns / 1ps

module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/itoa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor must hold while busy.
module itoa_div #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [itoa_pkg::BASE_W-1:0]   divisor,
  output logic                          done,
  output logic [VALUE_WIDTH-1:0]        quotient,
  output logic [itoa_pkg::DIGIT_W-1:0]  remainder
);

  import itoa_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [DIGIT_W-1:0]     rem_r;

  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       diff;
  logic                   fits;

  always_comb begin
    trial = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      quo_r  <= '0;
      rem_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(VALUE_WIDTH);
        quo_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[VALUE_WIDTH-2:0], fits};
        rem_r <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hw/rtl/integer_to_radix_ascii_core.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload                                  Dir
// -------  --------------------  ---------------------------------------  ---
// in_      in_valid / in_ready   in_value[VALUE_WIDTH-1:0] s, in_base[5:0] in
// out_     out_valid / out_ready out_char_out[7:0], out_last, out_bad_base out
//
// Each digit takes one division on the shared bit-serial divider, and a
// negative value adds a minus sign; a bad base skips the divider.
// in_ready is high only while the sequencer is idle, one conversion at a time.
// Output stalls hold the sequencer; a finished character waits in the output
// register while the next input transaction may already be accepted.
// Reset is synchronous, active low, and clears control and working state.
module integer_to_radix_ascii_core #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [VALUE_WIDTH-1:0]      in_value,
  input  logic [itoa_pkg::BASE_W-1:0]        in_base,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]        out_char_out,
  output logic                               out_last,
  output logic                               out_bad_base
);

  import itoa_pkg::*;

  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAD,
    S_DIV,
    S_SIGN,
    S_RD,
    S_EMIT
  } state_t;

  state_t                 state_r,   state_nxt;
  logic [BASE_W-1:0]      base_r,    base_nxt;
  logic [VALUE_WIDTH-1:0] wq_r,      wq_nxt;      // working quotient
  logic [CNT_W-1:0]       count_r,   count_nxt;   // digits produced
  logic                   neg_r,     neg_nxt;
  logic [ADDR_W-1:0]      idx_r,     idx_nxt;     // digit being read back
  logic                   start_r,   start_nxt;
  logic                   ovalid_r,  ovalid_nxt;
  logic [CHAR_W-1:0]      ochar_r,   ochar_nxt;
  logic                   olast_r,   olast_nxt;
  logic                   obad_r,    obad_nxt;

  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]     div_rem;
  logic                   ram_we;
  logic [DIGIT_W-1:0]     ram_rdata;

  logic                   in_fire;
  logic                   slot_free;
  logic                   base_bad;
  logic [VALUE_WIDTH-1:0] val_u;
  logic [VALUE_WIDTH-1:0] mag;
  logic [CNT_W-1:0]       count_inc;

  itoa_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (wq_r),
    .divisor  (base_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Digit store, least significant first; read back in reverse order.
  itoa_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(div_rem),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    in_fire   = in_valid && in_ready;
    slot_free = !ovalid_r || out_ready;
    base_bad  = (in_base < BASE_MIN) || (in_base > BASE_MAX);
    val_u     = in_value;
    mag       = val_u[VALUE_WIDTH-1] ? (~val_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : val_u;
    count_inc = count_r + 1'b1;
    ram_we    = (state_r == S_DIV) && div_done;
  end

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    wq_nxt     = wq_r;
    count_nxt  = count_r;
    neg_nxt    = neg_r;
    idx_nxt    = idx_r;
    start_nxt  = 1'b0;
    // Drop the held character once the consumer takes it.
    ovalid_nxt = ovalid_r && !out_ready;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    obad_nxt   = obad_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (base_bad) begin
            state_nxt = S_BAD;
          end else begin
            // Latch base and magnitude, kick off the first division.
            base_nxt  = in_base;
            neg_nxt   = val_u[VALUE_WIDTH-1];
            wq_nxt    = mag;
            count_nxt = '0;
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end

      S_BAD: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CHAR_NUL;
          olast_nxt  = 1'b1;
          obad_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_DIV: begin
        if (div_done) begin
          // Remainder goes to the store at count_r; advance the count.
          wq_nxt    = div_quo;
          count_nxt = count_inc;
          idx_nxt   = count_r[ADDR_W-1:0];
          if ((div_quo == '0) || (count_inc == CNT_W'(VALUE_WIDTH))) begin
            state_nxt = neg_r ? S_SIGN : S_RD;
          end else begin
            start_nxt = 1'b1;
          end
        end
      end

      S_SIGN: begin
        // At least one digit always follows the sign.
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CHAR_MINUS;
          olast_nxt  = 1'b0;
          obad_nxt   = 1'b0;
          state_nxt  = S_RD;
        end
      end

      S_RD: begin
        // Wait out the registered read of idx_r.
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = digit_char(ram_rdata);
          olast_nxt  = (idx_r == '0);
          obad_nxt   = 1'b0;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      base_r   <= '0;
      wq_r     <= '0;
      count_r  <= '0;
      neg_r    <= 1'b0;
      idx_r    <= '0;
      start_r  <= 1'b0;
      ovalid_r <= 1'b0;
      ochar_r  <= '0;
      olast_r  <= 1'b0;
      obad_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      wq_r     <= wq_nxt;
      count_r  <= count_nxt;
      neg_r    <= neg_nxt;
      idx_r    <= idx_nxt;
      start_r  <= start_nxt;
      ovalid_r <= ovalid_nxt;
      ochar_r  <= ochar_nxt;
      olast_r  <= olast_nxt;
      obad_r   <= obad_nxt;
    end
  end

  assign out_valid    = ovalid_r;
  assign out_char_out = ochar_r;
  assign out_last     = olast_r;
  assign out_bad_base = obad_r;

endmodule

### tb/sv/itoa_char_checker.sv
`timescale 1ns / 1ps

module itoa_char_checker #(
  parameter int VW = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [VW-1:0]                 in_value,
  input  logic [itoa_pkg::BASE_W-1:0]   in_base,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [itoa_pkg::CHAR_W-1:0]   out_char_out,
  input  logic                          out_last,
  input  logic                          out_bad_base,
  output int                            fail_count,
  output int                            pending
);
  import itoa_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } char_rec_t;

  char_rec_t expected_chars[$];

  // Build the character string for one conversion, most significant first.
  function automatic void predict_conversion(input logic [VW-1:0] value,
                                             input logic [BASE_W-1:0] base);
    logic [VW-1:0]      quot;
    logic [VW-1:0]      radix;
    logic [DIGIT_W-1:0] rems [VW];
    logic [CHAR_W-1:0]  d8;
    logic               neg;
    int                 n;
    int                 k;
    if (base < BASE_MIN || base > BASE_MAX) begin
      expected_chars.push_back({CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    radix = {{(VW-BASE_W){1'b0}}, base};
    neg   = value[VW-1];
    quot  = neg ? (~value + 1'b1) : value;
    n = 0;
    do begin
      rems[n] = DIGIT_W'(quot % radix);
      quot    = quot / radix;
      n++;
    end while (quot != 0 && n < VW);
    if (neg)
      expected_chars.push_back({CHAR_MINUS, (n == 0), 1'b0});
    for (k = n - 1; k >= 0; k--) begin
      d8 = {{(CHAR_W-DIGIT_W){1'b0}}, rems[k]};
      d8 = (rems[k] < 10) ? (CHAR_ZERO + d8) : (CHAR_A + d8 - 8'd10);
      expected_chars.push_back({d8, (k == 0), 1'b0});
    end
  endfunction

  always @(posedge clk) begin : watch
    char_rec_t seen;
    char_rec_t want;
    if (!rst_n) begin
      expected_chars.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_char_out, out_last, out_bad_base};
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char %h last %b bad_base %b, nothing pending",
                   $time, seen.ch, seen.last, seen.bad);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (seen.ch !== want.ch || seen.last !== want.last || seen.bad !== want.bad) begin
            $display("%0t: mismatch expected char %h last %b bad_base %b, actual char %h last %b bad_base %b",
                     $time, want.ch, want.last, want.bad, seen.ch, seen.last, seen.bad);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        predict_conversion(in_value, in_base);
      pending <= expected_chars.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import itoa_pkg::*;

  localparam int VW        = VALUE_WIDTH_DEF;
  localparam int RAND_ITEMS = 385;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [VW-1:0]       in_value;
  logic [BASE_W-1:0]   in_base;
  logic                out_valid;
  logic                out_ready;
  logic [CHAR_W-1:0]   out_char_out;
  logic                out_last;
  logic                out_bad_base;

  int                  fail_count;
  int                  pending;

  // Source and sink pacing state
  bit                  burst_src;
  bit                  quiet_sink;
  int                  stall_left;

  integer_to_radix_ascii_core #(.VALUE_WIDTH(VW)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_base      (in_base),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .out_bad_base (out_bad_base)
  );

  // Watch both channels, predict each string, compare every character
  itoa_char_checker #(.VW(VW)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_base      (in_base),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .out_bad_base (out_bad_base),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; well beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Sink: after every accepted character, draw whether and how long to drop ready.
  // Re-decide at string boundaries whether to run a stretch with no stalls.
  always @(posedge clk) begin : sink_pacing
    int draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      quiet_sink <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_last)
        quiet_sink <= ($urandom_range(0, 4) == 0);
      draw = quiet_sink ? 0 : $urandom_range(0, 19);
      out_ready  <= (draw == 0);
      stall_left <= draw;
    end else if (!out_ready) begin
      if (stall_left <= 1)
        out_ready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  // Present one transaction after a random gap and hold it until accepted.
  // Called and returns on a rising edge; valid stays high when no gap follows.
  task automatic send_item(input logic [VW-1:0] v, input logic [BASE_W-1:0] b);
    int gap;
    gap = burst_src ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_base  <= b;
    // Sample ready mid-cycle so the handshake is free of edge races
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Hold off the source until every predicted character has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mix of wide random, small, extreme and shifted magnitudes of either sign
  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    int            sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = $urandom;
    end else if (sel < 65) begin
      v = VW'($urandom_range(0, 200)) - VW'(100);
    end else if (sel < 80) begin
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = VW'(1);
        2:       v = '1;
        3:       v = {1'b1, {(VW-1){1'b0}}};
        4:       v = {1'b0, {(VW-1){1'b1}}};
        default: v = {1'b1, {(VW-2){1'b0}}, 1'b1};
      endcase
    end else begin
      v = $urandom >> $urandom_range(0, VW - 1);
      if ($urandom_range(0, 1))
        v = ~v + 1'b1;
    end
    return v;
  endfunction

  initial begin : stimulus
    logic [BASE_W-1:0] b;
    int                i;
    int                sel;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_value  <= '0;
    in_base   <= '0;
    burst_src  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, sign extremes, digit/letter boundaries, invalid bases
    send_item(32'd0, 6'd10);
    send_item(32'd0, 6'd2);
    send_item(32'h7FFF_FFFF, 6'd2);
    send_item(32'h8000_0000, 6'd2);
    send_item(32'h8000_0000, 6'd36);
    send_item(32'h8000_0000, 6'd10);
    send_item(32'hFFFF_FFFF, 6'd2);
    send_item(32'hFFFF_FFFF, 6'd36);
    send_item(32'h7FFF_FFFF, 6'd36);
    send_item(32'd35, 6'd36);
    send_item(-32'sd35, 6'd36);
    send_item(32'd36, 6'd36);
    send_item(32'd9, 6'd10);
    send_item(32'd10, 6'd16);
    send_item(32'd255, 6'd16);
    send_item(-32'sd1234567890, 6'd10);
    send_item(32'h5555_5555, 6'd3);
    send_item(32'hAAAA_AAAA, 6'd7);
    send_item(32'h8000_0000, 6'd32);
    send_item(32'hFFFF_FFFF, 6'd10);
    send_item(32'd1, 6'd2);
    send_item(32'd12345, 6'd0);
    send_item(-32'sd5, 6'd1);
    send_item(32'd777, 6'd37);
    send_item(32'hFFFF_FFFF, 6'd63);
    drain_results();

    // Random: mostly valid bases, some invalid; bursts with no source gaps
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0)
        burst_src = ($urandom_range(0, 3) == 0);
      if (i == RAND_ITEMS / 2)
        drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        b = $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 1))
                                 : BASE_W'($urandom_range(37, 63));
      end else if (sel < 30) begin
        case ($urandom_range(0, 4))
          0:       b = 6'd2;
          1:       b = 6'd8;
          2:       b = 6'd10;
          3:       b = 6'd16;
          default: b = 6'd36;
        endcase
      end else begin
        b = BASE_W'($urandom_range(2, 36));
      end
      send_item(pick_value(), b);
    end
    in_valid <= 1'b0;

    // Let the last string drain, then stay idle to catch any stray characters
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ram.sv
hw/rtl/itoa_div.sv
hw/rtl/integer_to_radix_ascii_core.sv
tb/sv/itoa_char_checker.sv
tb/sv/testbench.sv
